// ----- sv/lrtm_pkg.sv -----
// Shared types, constants and functions for the log range tone mapper.
// Used by lrtm_ctrl, lrtm_dp and log_range_tone_map; depends on nothing.
`timescale 1ns / 1ps

package lrtm_pkg;

  // Mantissa table size for the fixed-point log2.
  localparam int LOG_TABLE_BITS = 10;
  localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;

  // Q6.16 log2 and divider widths.
  localparam int FRAC_W  = 16;
  localparam int INT_W   = 6;
  localparam int LOG_W   = INT_W + FRAC_W;
  localparam int LEVEL_W = 16;
  localparam int NUM_W   = LOG_W + LEVEL_W;
  localparam int CNT_W   = 4;

  localparam logic [31:0] RESET_LOW  = 32'h749DC5AE;
  localparam logic [31:0] RESET_HIGH = 32'hF49DC5AE;
  localparam logic [63:0] FIX_ONE    = 64'h0000_0000_0100_0000;
  localparam logic [63:0] MAG_CAP    = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Input action codes.
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  // Register byte addresses.
  localparam logic [2:0] ADDR_SWAP = 3'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             conv;
    logic             diff;
    logic             log_r;
    logic             log_d;
    logic             log_e;
    logic             div_step;
    logic [CNT_W-1:0] div_bit;
    logic             out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
    logic is_map;
  } stat_t;

  typedef logic [FRAC_W-1:0] log_tab_t [TAB_SIZE];

  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic is_nan(input logic [31:0] b);
    return (&b[30:23]) && (|b[22:0]);
  endfunction

  // Monotonic key for float ordering; -0 and +0 share a key.
  function automatic logic [32:0] order_key(input logic [31:0] b);
    logic [32:0] mag;
    mag = {2'b00, b[30:0]};
    return b[31] ? (33'h080000000 - mag) : (33'h080000000 + mag);
  endfunction

  function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
    return !(is_nan(a) || is_nan(b)) && (order_key(a) < order_key(b));
  endfunction

  // Float32 to signed fixed point with 24 fraction bits, truncated and capped.
  function automatic logic signed [63:0] to_fixed(input logic [31:0] b);
    logic [7:0]  e;
    logic [63:0] m;
    logic [63:0] mag;
    e = b[30:23];
    m = {40'd0, 1'b1, b[22:0]};
    if (e == 8'd255) begin
      mag = MAG_CAP;
    end else if (e == 8'd0) begin
      mag = 64'd0;
    end else if (e >= 8'd126) begin
      mag = ((e - 8'd126) > 8'd38) ? MAG_CAP : (m << (e - 8'd126));
    end else begin
      mag = ((8'd126 - e) >= 8'd64) ? 64'd0 : (m >> (8'd126 - e));
    end
    return signed'(b[31] ? (64'd0 - mag) : mag);
  endfunction

  // Fraction of log2(1 + i/TAB_SIZE) by repeated squaring; built at elaboration.
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [15:0] acc;
    for (int i = 0; i < TAB_SIZE; i++) begin
      y   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      acc = 16'd0;
      for (int k = 0; k < FRAC_W; k++) begin
        y   = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'd1 << 31)) begin
          acc[0] = 1'b1;
          y      = y >> 1;
        end
      end
      t[i] = acc;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ----- sv/lrtm_ctrl.sv -----
// Sequencing state machine of the log range tone mapper.
// Depends on lrtm_pkg; drives the command struct of lrtm_dp.
`timescale 1ns / 1ps

module lrtm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lrtm_pkg::stat_t st,
  output lrtm_pkg::cmd_t  cmd
);
  import lrtm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_CONV = 9'b000000100,
    S_DIFF = 9'b000001000,
    S_LOGR = 9'b000010000,
    S_LOGD = 9'b000100000,
    S_LOGE = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.div_bit  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.is_map) begin
          state_nxt = S_CONV;
        end else begin
          cmd.scan  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_LOGR;
      end
      S_LOGR: begin
        cmd.log_r = 1'b1;
        state_nxt = S_LOGD;
      end
      S_LOGD: begin
        cmd.log_d = 1'b1;
        state_nxt = S_LOGE;
      end
      S_LOGE: begin
        cmd.log_e = 1'b1;
        cnt_nxt   = CNT_W'(LEVEL_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The divider runs its full count before a result is offered.
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_DONE))
    else $error("divider did not finish into the done state");

  // A new transfer is never taken while the divider runs.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !cmd.load)
    else $error("input taken during division");

  // Leaving the done state always loads the output register.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |-> cmd.out_load)
    else $error("result dropped on leaving done");

endmodule

// ----- sv/lrtm_dp.sv -----
// Datapath of the log range tone mapper: bounds, fixed-point log2, divider.
// Depends on lrtm_pkg; steered by the command struct from lrtm_ctrl.
`timescale 1ns / 1ps

module lrtm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrtm_pkg::cmd_t                cmd,
  output lrtm_pkg::stat_t               st,
  input  logic                          swap_bytes,
  input  logic                          in_action,
  input  logic [31:0]                   in_sample_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrtm_pkg::LEVEL_W-1:0]  out_level
);
  import lrtm_pkg::*;

  logic [31:0]         x_r, low_r, high_r;
  logic                act_r;
  logic signed [63:0]  xf_r, lof_r, hif_r;
  logic                nan_r, rpos_r;
  logic [63:0]         ru_r, du_r;
  logic [INT_W-1:0]    lint_r;
  logic [FRAC_W-1:0]   tab_q_r;
  logic [LOG_W-1:0]    lr_r, div_r;
  logic                force_r;
  logic [LEVEL_W-1:0]  force_val_r, q_r, out_level_r;
  logic [NUM_W-1:0]    rem_r;
  logic                out_valid_r;

  // Shared log2 encoder: top set bit at or above 24, and the table index below it.
  logic [63:0]               enc_u;
  logic [5:0]                enc_p;
  logic [LOG_TABLE_BITS-1:0] enc_idx;
  logic [63:0]               enc_sh;

  assign enc_u = cmd.log_r ? ru_r : du_r;

  always_comb begin
    enc_p = 6'd24;
    for (int k = 24; k < 64; k++) begin
      if (enc_u[k]) begin
        enc_p = 6'(k);
      end
    end
    enc_sh  = enc_u >> (enc_p - 6'(LOG_TABLE_BITS));
    enc_idx = enc_sh[LOG_TABLE_BITS-1:0];
  end

  // Range and offset with one extra bit for the sign.
  logic signed [64:0] r_w, d_w;
  assign r_w = {hif_r[63], hif_r} - {lof_r[63], lof_r};
  assign d_w = {xf_r[63], xf_r} - {lof_r[63], lof_r};

  logic [LOG_W-1:0] ld_w;
  assign ld_w = {lint_r, tab_q_r};

  logic [NUM_W-1:0] shifted_w;
  assign shifted_w = {{LEVEL_W{1'b0}}, div_r} << cmd.div_bit;

  // Bound tracking on scan commands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= RESET_LOW;
      high_r <= RESET_HIGH;
    end else if (cmd.scan) begin
      if (!f_less(low_r, x_r)) begin
        low_r <= x_r;
      end
      if (!f_less(x_r, high_r)) begin
        high_r <= x_r;
      end
    end
  end

  // Map pipeline steps and the restoring divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= swap_bytes ? byte_reverse(in_sample_bits) : in_sample_bits;
      act_r <= in_action;
    end
    if (cmd.conv) begin
      xf_r  <= to_fixed(x_r);
      lof_r <= to_fixed(low_r);
      hif_r <= to_fixed(high_r);
      nan_r <= is_nan(x_r) || is_nan(low_r) || is_nan(high_r);
    end
    if (cmd.diff) begin
      rpos_r <= (r_w > 65'sd0);
      ru_r   <= (r_w > 65'sd0) ? (r_w[63:0] + FIX_ONE) : FIX_ONE;
      du_r   <= d_w[64] ? FIX_ONE : (d_w[63:0] + FIX_ONE);
    end
    if (cmd.log_r || cmd.log_d) begin
      lint_r  <= INT_W'(enc_p - 6'd24);
      tab_q_r <= LOG_TAB[enc_idx];
    end
    if (cmd.log_d) begin
      lr_r <= ld_w;
    end
    if (cmd.log_e) begin
      force_r     <= nan_r || !rpos_r || (lr_r == '0) || (ld_w >= lr_r);
      force_val_r <= (nan_r || !rpos_r || (lr_r == '0)) ? '0 : LEVEL_MAX;
      rem_r       <= NUM_W'(ld_w) * NUM_W'(LEVEL_MAX);
      div_r       <= lr_r;
      q_r         <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= shifted_w) begin
        rem_r            <= rem_r - shifted_w;
        q_r[cmd.div_bit] <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_level_r <= force_r ? force_val_r : q_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign st.out_full = out_valid_r && !out_ready;
  assign st.is_map   = (act_r == ACT_MAP);

  // After a scan the minimum is the sample or still below it.
  a_low_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |=> (low_r == $past(x_r)) || f_less(low_r, $past(x_r)))
    else $error("minimum not updated correctly");

  // After a scan the maximum is the sample or still above it.
  a_high_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |=> (high_r == $past(x_r)) || f_less($past(x_r), high_r))
    else $error("maximum not updated correctly");

  // A divided level stays below full scale since the offset log is below the range log.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !force_r) |-> (q_r != LEVEL_MAX))
    else $error("quotient reached full scale");

endmodule

// ----- sv/log_range_tone_map.sv -----
// Log range tone mapper: float32 greyscale samples to 16-bit log-scaled levels.
// A scan transfer ends after its decode step; a map transfer runs the 16-step
// restoring divider that forms 65535*log2(1+x-min)/log2(1+max-min); the
// remaining steps are conversion, range subtraction and two registered log2
// table reads. A finished level waits in the output register, and a new item
// is taken once the map sequence ends.
// Register 0 (byte address 0), bit 0: byte swap of each sample word, reset 1.
// Top level; depends on lrtm_pkg, lrtm_ctrl and lrtm_dp.
`timescale 1ns / 1ps

module log_range_tone_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [31:0]                   in_sample_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrtm_pkg::LEVEL_W-1:0]  out_level,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lrtm_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  swap_r;

  // Configuration register write and read back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == ADDR_SWAP)) begin
      swap_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SWAP) ? {31'd0, swap_r} : 32'd0;

  lrtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lrtm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .swap_bytes     (swap_r),
    .in_action      (in_action),
    .in_sample_bits (in_sample_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for log_range_tone_map: map results checked against a built-in
// level predictor held in a small scoreboard class, which scan transfers update.
// Depends on lrtm_pkg (constants and codes) and the log_range_tone_map RTL.
`timescale 1ns / 1ps

module tb;
  import lrtm_pkg::*;

  // Predicts grey levels and holds the levels still owed by the block.
  class level_board;
    logic [31:0] min_bits, max_bits;
    logic        swap_on;
    logic [15:0] frac_tab [TAB_SIZE];
    logic [15:0] owed_levels [$];
    int          errors;

    function void clear_state();
      logic [63:0] y;
      logic [15:0] acc;
      for (int i = 0; i < TAB_SIZE; i++) begin
        y   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
        acc = 16'd0;
        for (int k = 0; k < 16; k++) begin
          y   = (y * y) >> 30;
          acc = acc << 1;
          if (y >= (64'd1 << 31)) begin
            acc[0] = 1'b1;
            y      = y >> 1;
          end
        end
        frac_tab[i] = acc;
      end
      min_bits = RESET_LOW;
      max_bits = RESET_HIGH;
      swap_on  = 1'b1;
      errors   = 0;
    endfunction

    function bit nan_word(logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    function logic [32:0] sort_key(logic [31:0] b);
      logic [32:0] m;
      m = {2'b00, b[30:0]};
      return b[31] ? (33'h080000000 - m) : (33'h080000000 + m);
    endfunction

    function bit below(logic [31:0] a, logic [31:0] b);
      if (nan_word(a) || nan_word(b)) return 0;
      return sort_key(a) < sort_key(b);
    endfunction

    function logic signed [63:0] as_q24(logic [31:0] b);
      int unsigned e;
      logic [63:0] m, mag;
      e = b[30:23];
      m = {40'd0, 1'b1, b[22:0]};
      if (e == 255) mag = MAG_CAP;
      else if (e == 0) mag = 0;
      else if (e >= 126) mag = (e - 126 > 38) ? MAG_CAP : (m << (e - 126));
      else mag = (126 - e >= 64) ? 64'd0 : (m >> (126 - e));
      return b[31] ? -$signed(mag) : $signed(mag);
    endfunction

    function logic [31:0] log2_q16(logic [63:0] u);
      int p;
      p = 63;
      while (p > 24 && !u[p]) p--;
      return ((p - 24) << 16) | frac_tab[(u >> (p - LOG_TABLE_BITS)) & (TAB_SIZE - 1)];
    endfunction

    function logic [15:0] grey_level(logic [31:0] x);
      logic signed [63:0] lo, r, d;
      logic [31:0] lr, ld;
      if (nan_word(x) || nan_word(min_bits) || nan_word(max_bits)) return 0;
      lo = as_q24(min_bits);
      r  = as_q24(max_bits) - lo;
      if (r <= 0) return 0;
      d = as_q24(x) - lo;
      if (d < 0) d = 0;
      lr = log2_q16(r + FIX_ONE);
      ld = log2_q16(d + FIX_ONE);
      if (lr == 0) return 0;
      if (ld >= lr) return 16'hFFFF;
      return 16'((64'(ld) * 65535) / lr);
    endfunction

    // Notes one accepted input transfer.
    function void note_input(logic act, logic [31:0] raw);
      logic [31:0] x;
      x = swap_on ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
      if (act == ACT_SCAN) begin
        if (!below(min_bits, x)) min_bits = x;
        if (!below(x, max_bits)) max_bits = x;
      end else begin
        owed_levels.push_back(grey_level(x));
      end
    endfunction

    // Checks one accepted output transfer.
    function void check_level(logic [15:0] got);
      logic [15:0] want;
      if (owed_levels.size() == 0) begin
        report("unexpected level", got, 0);
        return;
      end
      want = owed_levels.pop_front();
      if (got !== want) report("level", got, want);
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 30) $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_action;
  logic [31:0] in_sample_bits;
  logic        out_valid, out_ready;
  logic [15:0] out_level;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  level_board board;
  int         n_maps, n_scans, idle_cycles;
  bit         hold_sink, long_hold_req;

  log_range_tone_map DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold_req = 0;
      end
      out_ready <= ($urandom_range(0, 3) != 0) || hold_sink == 0 && $urandom_range(0, 1);
      @(posedge clk);
      if (out_valid && out_ready) board.check_level(out_level);
    end
  end

  // Watchdog on cycles with no transfer at all.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(logic act, logic [31:0] raw);
    in_valid       <= 1;
    in_action      <= act;
    in_sample_bits <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(act, raw);
    if (act == ACT_MAP) n_maps++; else n_scans++;
    // The block is busy after a transfer, so valid drops before the next item
    // is offered.
    in_valid <= 0;
    @(posedge clk);
    repeat (gap_len()) @(posedge clk);
  endtask

  task automatic drain();
    while (board.owed_levels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_swap(logic v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_SWAP; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.swap_on = v;
    @(posedge clk);
  endtask

  // Float word with random content: mostly ordinary values, some specials.
  function logic [31:0] rand_float();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {1'($urandom_range(0, 3) == 0), 8'($urandom_range(110, 150)),
                        23'($urandom)};
    if (r < 80) return $urandom;
    if (r < 85) return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom)};
    if (r < 90) return {1'($urandom), 8'h00, 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(160, 254)), 23'($urandom)};
  endfunction

  function logic [31:0] wire_form(logic [31:0] x);
    return board.swap_on ? {x[7:0], x[15:8], x[23:16], x[31:24]} : x;
  endfunction

  initial begin
    board = new();
    board.clear_state();
    rst_n = 0; in_valid = 0; in_action = 0; in_sample_bits = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    hold_sink = 0; long_hold_req = 0; n_maps = 0; n_scans = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: map before any scan gives 0; extremes, NaN, infinities.
    send_item(ACT_MAP, wire_form(32'h3F800000));
    send_item(ACT_SCAN, wire_form(32'h00000000));
    send_item(ACT_SCAN, wire_form(32'h80000000));
    send_item(ACT_MAP, wire_form(32'h3F800000));
    send_item(ACT_SCAN, wire_form(32'h42C80000));
    send_item(ACT_MAP, wire_form(32'h41200000));
    send_item(ACT_MAP, wire_form(32'hC0000000));
    send_item(ACT_MAP, wire_form(32'h43C80000));
    send_item(ACT_MAP, wire_form(32'h7FC00001));
    send_item(ACT_MAP, wire_form(32'h7F800000));
    send_item(ACT_MAP, wire_form(32'hFFFFFFFF));
    send_item(ACT_MAP, wire_form(32'h00000001));
    send_item(ACT_SCAN, wire_form(32'h7F7FFFFF));
    send_item(ACT_MAP, wire_form(32'h5F000000));
    send_item(ACT_SCAN, wire_form(32'h7FC00000));
    send_item(ACT_MAP, wire_form(32'h3F800000));
    drain();

    // Random phases over both swap settings; each phase scans more samples into the range.
    for (int ph = 0; ph < 6; ph++) begin
      write_swap(ph % 2);
      if (ph == 2) begin
        long_hold_req = 1;
        hold_sink = 1;
      end
      for (int j = 0; j < 150; j++) begin
        if ($urandom_range(0, 2) == 0) send_item(ACT_SCAN, wire_form(rand_float()));
        else if ($urandom_range(0, 19) == 0) send_item(ACT_MAP, $urandom);
        else send_item(ACT_MAP, wire_form(rand_float()));
        if (j == 75 && ph == 4) drain();
      end
      hold_sink = 0;
      drain();
    end

    $display("Covered %0d scan and %0d map transfers over both byte orders,",
             n_scans, n_maps);
    $display("including NaN, infinite, subnormal and out-of-range samples.");
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
